// ===== hw/rtl/eprh_pkg.sv =====
// shared types and constants of the ecg peak and heart rate block
package eprh_pkg;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned THR_W      = 18;
   localparam int unsigned RATE_W     = 13;
   localparam int unsigned SR_W       = 10;
   localparam int unsigned REFR_W     = 10;
   localparam int unsigned PER_W      = 14;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned MUL_W      = 17;
   localparam int unsigned RATE_NUM_W = 20;
   localparam int unsigned RATE_SCALE = 960;
   localparam int unsigned RATE_MAX   = 8191;

   localparam logic [SR_W-1:0]   SR_RESET   = 10'd250;
   localparam logic [REFR_W-1:0] REFR_RESET = 10'd50;
   localparam logic [PER_W-1:0]  PER_RESET  = 14'd2500;
   localparam logic [THR_W-1:0]  THR_RESET  = 18'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLING_RATE     = 2'd0,
      CSR_REFRACTORY        = 2'd1,
      CSR_RECALC_PERIOD     = 2'd2,
      CSR_INITIAL_THRESHOLD = 2'd3
   } eprh_csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDP,
      ST_RDH,
      ST_UPD,
      ST_SQX,
      ST_QAD,
      ST_DIV,
      ST_DIVW,
      ST_SSH,
      ST_SSM,
      ST_SSL,
      ST_SSE,
      ST_VAR,
      ST_SQS,
      ST_SQW,
      ST_FIN
   } eprh_state_type;

   typedef enum logic [2:0] {
      MUL_OLD,
      MUL_X,
      MUL_HH,
      MUL_HL,
      MUL_LL
   } eprh_mul_sel_type;

   typedef struct packed {
      logic             take_in;
      logic             rd_prev;
      logic             rd_head;
      logic             cap_prev;
      logic             update;
      logic             q_sub;
      logic             q_add;
      logic             mul_en;
      eprh_mul_sel_type mul_sel;
      logic             rate_start;
      logic             rate_load;
      logic             acc_hh;
      logic             acc_hl;
      logic             acc_ll;
      logic             var_load;
      logic             sqrt_start;
      logic             thr_load;
      logic             out_load;
   } eprh_cmd_type;

   typedef struct packed {
      logic rate_due;
      logic recalc_due;
      logic div_done;
      logic sqrt_done;
   } eprh_status_type;

endpackage

// ===== hw/rtl/eprh_req_if.sv =====
// input item channel
interface eprh_req_if;
   import eprh_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/eprh_rsp_if.sv =====
// result item channel
interface eprh_rsp_if;
   import eprh_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_echo;
   logic                       peak_found;
   logic        [RATE_W-1:0]   beat_rate;
   logic signed [THR_W-1:0]    threshold_now;
   modport source (output valid, output sample_echo, output peak_found,
                   output beat_rate, output threshold_now, input ready);
   modport sink   (input valid, input sample_echo, input peak_found,
                   input beat_rate, input threshold_now, output ready);
endinterface

// ===== hw/rtl/eprh_csr_if.sv =====
// configuration write channel
interface eprh_csr_if;
   import eprh_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/eprh_ram.sv =====
// generic single write, single read ram with registered read
module eprh_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/eprh_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module eprh_div #(
   parameter int unsigned NUM_W = 20,
   parameter int unsigned DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             qbit;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], qbit};
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
endmodule

// ===== hw/rtl/eprh_isqrt.sv =====
// digit by digit integer square root, two radicand bits per cycle
module eprh_isqrt #(
   parameter int unsigned VAL_W = 34
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VAL_W-1:0]   value,
   output logic               done,
   output logic [VAL_W/2-1:0] root
);
   localparam int unsigned ROOT_W = VAL_W / 2;
   localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

   logic [VAL_W-1:0]  val_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W+2:0] rem_sh;
   logic [ROOT_W+2:0] trial;
   logic              rbit;

   assign rem_sh = {rem_ff, val_ff[VAL_W-1:VAL_W-2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign rbit   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[VAL_W-3:0], 2'b00};
         rem_ff  <= rbit ? (ROOT_W+1)'(rem_sh - trial) : rem_sh[ROOT_W:0];
         root_ff <= {root_ff[ROOT_W-2:0], rbit};
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== hw/rtl/eprh_datapath.sv =====
// sample store, running sums, peak test, rate and threshold arithmetic
module eprh_datapath #(
   parameter int unsigned STORE_DEPTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  eprh_pkg::eprh_cmd_type                cmd,
   output eprh_pkg::eprh_status_type             status,
   input  logic signed [eprh_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  csr_we,
   input  logic [eprh_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [eprh_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic signed [eprh_pkg::SAMPLE_W-1:0]  rsp_sample_echo,
   output logic                                  rsp_peak_found,
   output logic [eprh_pkg::RATE_W-1:0]           rsp_beat_rate,
   output logic signed [eprh_pkg::THR_W-1:0]     rsp_threshold_now
);
   import eprh_pkg::*;

   // store depth must be a power of two; the module does not check it
   localparam int unsigned LOG = $clog2(STORE_DEPTH);
   localparam int unsigned SW  = 17 + LOG;
   localparam int unsigned AW  = 16 + LOG;
   localparam int unsigned HW  = (AW + 1) / 2;
   localparam int unsigned QW  = 31 + LOG;
   localparam int unsigned DFW = 4 * HW;
   localparam int unsigned VW  = DFW - 2 * LOG;
   localparam int unsigned RW  = VW / 2;

   logic [SR_W-1:0]           sr_ff;
   logic [REFR_W-1:0]         refr_ff;
   logic [PER_W-1:0]          rp_ff;
   logic signed [THR_W-1:0]   thr_ff;
   logic [RATE_W-1:0]         rate_ff;
   logic [PER_W-1:0]          pc_ff;
   logic [LOG-1:0]            head_ff;
   logic                      wrapped_ff;
   logic [LOG-1:0]            pos0_ff;
   logic [LOG-1:0]            pos1_ff;
   logic [1:0]                cnt_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic signed [SW-1:0]      s_ff;
   logic [QW-1:0]             q_ff;
   logic signed [2*MUL_W-1:0] mul_ff;
   logic [DFW-1:0]            acc_ff;
   logic [VW-1:0]             var_ff;
   logic [LOG-1:0]            gap_ff;
   logic                      peak_ff;
   logic                      rate_due_ff;
   logic                      recalc_due_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff;
   logic                      out_peak_ff;
   logic [RATE_W-1:0]         out_rate_ff;
   logic signed [THR_W-1:0]   out_thr_ff;

   logic [SAMPLE_W-1:0]       rd_data;
   logic signed [SAMPLE_W-1:0] old;
   logic [LOG-1:0]            last;
   logic [LOG-1:0]            gap;
   logic                      peak;
   logic [PER_W-1:0]          period;
   logic [PER_W:0]            pc_inc;
   logic [SW-1:0]             s_abs;
   logic [HW-1:0]             s_hi;
   logic [HW-1:0]             s_lo;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic [DFW-1:0]            diff;
   logic signed [SAMPLE_W-1:0] mean;
   logic                      div_done;
   logic [RATE_NUM_W-1:0]     quot;
   logic                      sqrt_done;
   logic [RW-1:0]             root;

   eprh_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (head_ff),
      .wr_data (x_ff),
      .rd_en   (cmd.rd_prev | cmd.rd_head),
      .rd_addr (cmd.rd_prev ? head_ff - 1'b1 : head_ff),
      .rd_data (rd_data)
   );

   eprh_div #(
      .NUM_W (RATE_NUM_W),
      .DEN_W (LOG)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.rate_start),
      .num   (RATE_NUM_W'(sr_ff) * RATE_NUM_W'(RATE_SCALE)),
      .den   (gap_ff),
      .done  (div_done),
      .quot  (quot)
   );

   eprh_isqrt #(
      .VAL_W (VW)
   ) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (var_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   // entries never written read as zero until the head first wraps
   assign old    = wrapped_ff ? $signed(rd_data) : '0;
   assign last   = (cnt_ff >= 2'd2) ? pos1_ff : pos0_ff;
   assign gap    = head_ff - last;
   assign peak   = ($signed({{(THR_W-SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff}) > thr_ff)
                   && (x_ff > prev_ff)
                   && ((cnt_ff == 2'd0) || (32'(gap) > 32'(refr_ff)));
   assign period = (rp_ff == '0) ? PER_W'(1) : rp_ff;
   assign pc_inc = {1'b0, pc_ff} + 1'b1;

   assign s_abs  = s_ff[SW-1] ? SW'(-s_ff) : SW'(s_ff);
   assign s_hi   = s_abs[2*HW-1:HW];
   assign s_lo   = s_abs[HW-1:0];
   assign diff   = (DFW'(q_ff) << LOG) - acc_ff;
   assign mean   = SAMPLE_W'(s_ff >>> LOG);

   always_comb begin
      mul_a = MUL_W'(old);
      mul_b = MUL_W'(old);
      case (cmd.mul_sel)
         MUL_OLD: begin
            mul_a = MUL_W'(old);
            mul_b = MUL_W'(old);
         end
         MUL_X: begin
            mul_a = MUL_W'(x_ff);
            mul_b = MUL_W'(x_ff);
         end
         MUL_HH: begin
            mul_a = $signed(MUL_W'(s_hi));
            mul_b = $signed(MUL_W'(s_hi));
         end
         MUL_HL: begin
            mul_a = $signed(MUL_W'(s_hi));
            mul_b = $signed(MUL_W'(s_lo));
         end
         MUL_LL: begin
            mul_a = $signed(MUL_W'(s_lo));
            mul_b = $signed(MUL_W'(s_lo));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff         <= SR_RESET;
         refr_ff       <= REFR_RESET;
         rp_ff         <= PER_RESET;
         thr_ff        <= THR_RESET;
         rate_ff       <= '0;
         pc_ff         <= '0;
         head_ff       <= '0;
         wrapped_ff    <= 1'b0;
         pos0_ff       <= '0;
         pos1_ff       <= '0;
         cnt_ff        <= '0;
         s_ff          <= '0;
         q_ff          <= '0;
         rate_due_ff   <= 1'b0;
         recalc_due_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (eprh_csr_idx_type'(csr_index))
               CSR_SAMPLING_RATE:     sr_ff   <= csr_data[SR_W-1:0];
               CSR_REFRACTORY:        refr_ff <= csr_data[REFR_W-1:0];
               CSR_RECALC_PERIOD:     rp_ff   <= csr_data[PER_W-1:0];
               CSR_INITIAL_THRESHOLD: thr_ff  <= THR_W'($signed(csr_data));
               default: begin
               end
            endcase
         end
         if (cmd.update) begin
            s_ff          <= s_ff - SW'(old) + SW'(x_ff);
            head_ff       <= head_ff + 1'b1;
            if (head_ff == LOG'(STORE_DEPTH - 1)) begin
               wrapped_ff <= 1'b1;
            end
            rate_due_ff   <= peak && (cnt_ff >= 2'd2);
            recalc_due_ff <= (pc_ff == '0);
            pc_ff         <= (pc_inc >= {1'b0, period}) ? '0 : pc_inc[PER_W-1:0];
            if (peak) begin
               case (cnt_ff)
                  2'd0: begin
                     pos0_ff <= head_ff;
                     cnt_ff  <= 2'd1;
                  end
                  2'd1: begin
                     pos1_ff <= head_ff;
                     cnt_ff  <= 2'd2;
                  end
                  default: begin
                     pos0_ff <= pos1_ff;
                     pos1_ff <= head_ff;
                  end
               endcase
            end
         end
         if (cmd.q_sub) begin
            q_ff <= q_ff - QW'(mul_ff[30:0]);
         end
         if (cmd.q_add) begin
            q_ff <= q_ff + QW'(mul_ff[30:0]);
         end
         if (cmd.rate_load) begin
            rate_ff <= (quot > RATE_NUM_W'(RATE_MAX)) ? RATE_W'(RATE_MAX)
                                                      : quot[RATE_W-1:0];
         end
         if (cmd.thr_load) begin
            thr_ff <= THR_W'({{(THR_W-SAMPLE_W){mean[SAMPLE_W-1]}}, mean})
                      + THR_W'({root, 1'b0});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_in) begin
         x_ff <= req_sample;
      end
      if (cmd.cap_prev) begin
         prev_ff <= (wrapped_ff || (head_ff != '0)) ? $signed(rd_data) : '0;
      end
      if (cmd.update) begin
         gap_ff  <= gap;
         peak_ff <= peak;
      end
      if (cmd.mul_en) begin
         mul_ff <= mul_a * mul_b;
      end
      if (cmd.acc_hh) begin
         acc_ff <= DFW'(mul_ff[2*HW-1:0]) << (2 * HW);
      end
      if (cmd.acc_hl) begin
         acc_ff <= acc_ff + (DFW'(mul_ff[2*HW-1:0]) << (HW + 1));
      end
      if (cmd.acc_ll) begin
         acc_ff <= acc_ff + DFW'(mul_ff[2*HW-1:0]);
      end
      if (cmd.var_load) begin
         var_ff <= VW'(diff >> (2 * LOG));
      end
      if (cmd.out_load) begin
         out_sample_ff <= x_ff;
         out_peak_ff   <= peak_ff;
         out_rate_ff   <= rate_ff;
         out_thr_ff    <= thr_ff;
      end
   end

   assign status.rate_due   = rate_due_ff;
   assign status.recalc_due = recalc_due_ff;
   assign status.div_done   = div_done;
   assign status.sqrt_done  = sqrt_done;

   assign rsp_sample_echo   = out_sample_ff;
   assign rsp_peak_found    = out_peak_ff;
   assign rsp_beat_rate     = out_rate_ff;
   assign rsp_threshold_now = out_thr_ff;
endmodule

// ===== hw/rtl/eprh_controller.sv =====
// sequencing state machine and result valid flag
module eprh_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  eprh_pkg::eprh_status_type status,
   output eprh_pkg::eprh_cmd_type    cmd
);
   import eprh_pkg::*;

   eprh_state_type state_ff;
   eprh_state_type state_in;
   logic           rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_in = 1'b1;
               state_in    = ST_RDP;
            end
         end
         ST_RDP: begin
            cmd.rd_prev = 1'b1;
            state_in    = ST_RDH;
         end
         ST_RDH: begin
            cmd.rd_head  = 1'b1;
            cmd.cap_prev = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            cmd.update  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_OLD;
            state_in    = ST_SQX;
         end
         ST_SQX: begin
            cmd.q_sub   = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_X;
            state_in    = ST_QAD;
         end
         ST_QAD: begin
            cmd.q_add = 1'b1;
            if (status.rate_due) begin
               state_in = ST_DIV;
            end else if (status.recalc_due) begin
               state_in = ST_SSH;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            cmd.rate_start = 1'b1;
            state_in       = ST_DIVW;
         end
         ST_DIVW: begin
            if (status.div_done) begin
               cmd.rate_load = 1'b1;
               state_in      = status.recalc_due ? ST_SSH : ST_FIN;
            end
         end
         ST_SSH: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HH;
            state_in    = ST_SSM;
         end
         ST_SSM: begin
            cmd.acc_hh  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HL;
            state_in    = ST_SSL;
         end
         ST_SSL: begin
            cmd.acc_hl  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LL;
            state_in    = ST_SSE;
         end
         ST_SSE: begin
            cmd.acc_ll = 1'b1;
            state_in   = ST_VAR;
         end
         ST_VAR: begin
            cmd.var_load = 1'b1;
            state_in     = ST_SQS;
         end
         ST_SQS: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQW;
         end
         ST_SQW: begin
            if (status.sqrt_done) begin
               cmd.thr_load = 1'b1;
               state_in     = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded over an item not taken");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FIN))
      else $error("finished item left while output still blocked");

   a_taken_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && !cmd.out_load) |=> !rsp_valid_ff)
      else $error("result item delivered twice");
endmodule

// ===== hw/rtl/ecg_peak_heart_rate_top.sv =====
// top level of the ecg r peak detector with adaptive threshold and heart rate
// sequence: after accept, the read, update and running-sum states run, then the finish
// state loads the result once the output is free; a third or later peak adds the rate
// divider, and a recalculation sample adds the set-up states and the square root over the variance word
// flow: one item at a time; a new sample is taken only in idle, after the last result is loaded
// reset: synchronous, no clearing pass; store entries read as zero until first written
module ecg_peak_heart_rate_top #(
   parameter int unsigned STORE_DEPTH = 2048
) (
   input logic        clock,
   input logic        reset,
   eprh_req_if.sink   req_chan,
   eprh_rsp_if.source rsp_chan,
   eprh_csr_if.sink   csr_chan
);
   import eprh_pkg::*;

   eprh_cmd_type    cmd;
   eprh_status_type status;

   assign csr_chan.ready = 1'b1;

   eprh_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   eprh_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample        (req_chan.sample),
      .csr_we            (csr_chan.valid),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .rsp_sample_echo   (rsp_chan.sample_echo),
      .rsp_peak_found    (rsp_chan.peak_found),
      .rsp_beat_rate     (rsp_chan.beat_rate),
      .rsp_threshold_now (rsp_chan.threshold_now)
   );
endmodule
